// ===== src/lr3_pkg.sv =====
// shared constants, codes and item types for the 3d line rasteriser
`default_nettype none
package lr3_pkg;

	localparam int XY_BITS    = 10;
	localparam int Z_BITS     = 8;
	localparam int MAG_BITS   = (XY_BITS > Z_BITS) ? XY_BITS : Z_BITS;
	localparam int TWICE_BITS = MAG_BITS + 1;
	localparam int ERR_BITS   = MAG_BITS + 3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic               cmd;
		logic [XY_BITS-1:0] start_x;
		logic [XY_BITS-1:0] start_y;
		logic [Z_BITS-1:0]  start_z;
		logic [XY_BITS-1:0] end_x;
		logic [XY_BITS-1:0] end_y;
		logic [Z_BITS-1:0]  end_z;
	} cmd_item_t;

	typedef struct packed {
		logic [XY_BITS-1:0] point_x;
		logic [XY_BITS-1:0] point_y;
		logic [Z_BITS-1:0]  point_z;
		logic               last_point;
	} point_item_t;

endpackage
`default_nettype wire

// ===== src/lr3_cmd_if.sv =====
// valid/ready channel carrying command items
`default_nettype none
interface lr3_cmd_if;
	import lr3_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lr3_point_if.sv =====
// valid/ready channel carrying emitted points
`default_nettype none
interface lr3_point_if;
	import lr3_pkg::*;

	logic        valid;
	logic        ready;
	point_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/line_rasterizer_3d.sv =====
// 3d bresenham line stepper with a two-entry output buffer
// a step transfer's point is registered in the main register, or in the skid entry while that one is stalled
// throughput: one command per cycle, one point per cycle while the sink keeps up
// the two-entry output buffer (main register plus skid) catches a point that arrives during a stall
// reset: arst_n clears the line state and empties both buffer entries, so the block is idle
// and a step before the first load gives no point
`default_nettype none
module line_rasterizer_3d (
	input  wire          clk,
	input  wire          arst_n,
	lr3_cmd_if.sink      command,
	lr3_point_if.source  points
);
	import lr3_pkg::*;

	// line state
	logic [XY_BITS-1:0]         x_q, y_q;
	logic [Z_BITS-1:0]          z_q;
	logic signed [ERR_BITS-1:0] err_first_q, err_second_q;
	logic [TWICE_BITS-1:0]      twice_dx_q, twice_dy_q, twice_dz_q;
	logic [2:0]                 signs_q;
	axis_t                      major_q;
	logic [MAG_BITS-1:0]        left_q;

	// output buffer
	logic        main_valid_q, skid_valid_q;
	point_item_t main_data_q, skid_data_q;

	// load path signals
	logic [XY_BITS-1:0]         dx, dy;
	logic [Z_BITS-1:0]          dz;
	logic [MAG_BITS-1:0]        mag_x, mag_y, mag_z, major_len;
	logic [TWICE_BITS-1:0]      tw_x, tw_y, tw_z, tw_first_ld, tw_second_ld;
	axis_t                      major_ld;
	logic [2:0]                 signs_ld;
	logic signed [ERR_BITS-1:0] err_first_ld, err_second_ld;

	// step path signals
	logic [TWICE_BITS-1:0]      tw_maj, tw_first, tw_second;
	logic                       first_pos, second_pos;
	logic                       move_x, move_y, move_z;
	logic signed [ERR_BITS-1:0] err_first_nx, err_second_nx;
	logic [XY_BITS-1:0]         x_nx, y_nx;
	logic [Z_BITS-1:0]          z_nx;

	logic        accept, is_step, new_point, main_free;
	point_item_t point_now;

	// a transfer is refused only while the skid entry is occupied
	assign command.ready = !skid_valid_q;
	assign accept        = command.valid && command.ready;
	assign is_step       = (command.data.cmd == CMD_STEP);
	assign new_point     = accept && is_step && (left_q != '0);

	// magnitudes, step directions and the major axis for a load
	always_comb begin
		signs_ld[0] = (command.data.end_x < command.data.start_x);
		signs_ld[1] = (command.data.end_y < command.data.start_y);
		signs_ld[2] = (command.data.end_z < command.data.start_z);
		dx = signs_ld[0] ? command.data.start_x - command.data.end_x
			: command.data.end_x - command.data.start_x;
		dy = signs_ld[1] ? command.data.start_y - command.data.end_y
			: command.data.end_y - command.data.start_y;
		dz = signs_ld[2] ? command.data.start_z - command.data.end_z
			: command.data.end_z - command.data.start_z;
		mag_x = MAG_BITS'(dx);
		mag_y = MAG_BITS'(dy);
		mag_z = MAG_BITS'(dz);
		tw_x  = {mag_x, 1'b0};
		tw_y  = {mag_y, 1'b0};
		tw_z  = {mag_z, 1'b0};
		// ties go to x first, then y
		if (mag_x >= mag_y && mag_x >= mag_z) begin
			major_ld     = AXIS_X;
			major_len    = mag_x;
			tw_first_ld  = tw_y;
			tw_second_ld = tw_z;
		end else if (mag_y >= mag_z) begin
			major_ld     = AXIS_Y;
			major_len    = mag_y;
			tw_first_ld  = tw_x;
			tw_second_ld = tw_z;
		end else begin
			major_ld     = AXIS_Z;
			major_len    = mag_z;
			tw_first_ld  = tw_y;
			tw_second_ld = tw_x;
		end
		err_first_ld  = $signed({2'b00, tw_first_ld}) - $signed({3'b000, major_len});
		err_second_ld = $signed({2'b00, tw_second_ld}) - $signed({3'b000, major_len});
	end

	// one bresenham step from the stored state
	always_comb begin
		first_pos  = !err_first_q[ERR_BITS-1] && (err_first_q != '0);
		second_pos = !err_second_q[ERR_BITS-1] && (err_second_q != '0);
		case (major_q)
			AXIS_X: begin
				tw_maj    = twice_dx_q;
				tw_first  = twice_dy_q;
				tw_second = twice_dz_q;
				move_x    = 1'b1;
				move_y    = first_pos;
				move_z    = second_pos;
			end
			AXIS_Y: begin
				tw_maj    = twice_dy_q;
				tw_first  = twice_dx_q;
				tw_second = twice_dz_q;
				move_x    = first_pos;
				move_y    = 1'b1;
				move_z    = second_pos;
			end
			default: begin
				// minor order for major z is y then x
				tw_maj    = twice_dz_q;
				tw_first  = twice_dy_q;
				tw_second = twice_dx_q;
				move_x    = second_pos;
				move_y    = first_pos;
				move_z    = 1'b1;
			end
		endcase
		err_first_nx = err_first_q
			- (first_pos ? $signed({2'b00, tw_maj}) : $signed(ERR_BITS'(0)))
			+ $signed({2'b00, tw_first});
		err_second_nx = err_second_q
			- (second_pos ? $signed({2'b00, tw_maj}) : $signed(ERR_BITS'(0)))
			+ $signed({2'b00, tw_second});
		x_nx = !move_x ? x_q : (signs_q[0] ? x_q - 1'b1 : x_q + 1'b1);
		y_nx = !move_y ? y_q : (signs_q[1] ? y_q - 1'b1 : y_q + 1'b1);
		z_nx = !move_z ? z_q : (signs_q[2] ? z_q - 1'b1 : z_q + 1'b1);

		point_now.point_x    = x_q;
		point_now.point_y    = y_q;
		point_now.point_z    = z_q;
		point_now.last_point = (left_q == MAG_BITS'(1));
	end

	// line state register, updated on every accepted load or productive step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q          <= '0;
			y_q          <= '0;
			z_q          <= '0;
			err_first_q  <= '0;
			err_second_q <= '0;
			twice_dx_q   <= '0;
			twice_dy_q   <= '0;
			twice_dz_q   <= '0;
			signs_q      <= '0;
			major_q      <= AXIS_X;
			left_q       <= '0;
		end else if (accept && !is_step) begin
			// a load replaces any line still in progress
			x_q          <= command.data.start_x;
			y_q          <= command.data.start_y;
			z_q          <= command.data.start_z;
			err_first_q  <= err_first_ld;
			err_second_q <= err_second_ld;
			twice_dx_q   <= tw_x;
			twice_dy_q   <= tw_y;
			twice_dz_q   <= tw_z;
			signs_q      <= signs_ld;
			major_q      <= major_ld;
			left_q       <= major_len;
		end else if (new_point) begin
			x_q          <= x_nx;
			y_q          <= y_nx;
			z_q          <= z_nx;
			err_first_q  <= err_first_nx;
			err_second_q <= err_second_nx;
			left_q       <= left_q - 1'b1;
		end
	end

	// main register frees up when empty or when its point transfers this cycle
	assign main_free = !main_valid_q || points.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= new_point;
			end
		end else if (new_point) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload of the buffer, no reset
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_data_q <= skid_data_q;
			end else if (new_point) begin
				main_data_q <= point_now;
			end
		end else if (new_point) begin
			skid_data_q <= point_now;
		end
	end

	assign points.valid = main_valid_q;
	assign points.data  = main_data_q;

endmodule
`default_nettype wire

// ===== src/lr3_checker.sv =====
// port-level assertions for the 3d line rasteriser and their bind
`default_nettype none
module lr3_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_ready,
	input wire                      in_cmd,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire lr3_pkg::point_item_t out_data
);
	import lr3_pkg::*;

	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	// a stalled point holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled point changed or dropped");

	// with nothing buffered and no transfer in, no point can appear
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_xfer |=> !out_valid)
		else $error("point appeared without a command");

	// a load never produces a point
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_xfer && (in_cmd == CMD_LOAD) |=> !out_valid)
		else $error("load produced a point");

	// input back-pressure only when the output holds a point
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input refused with empty output");

endmodule

bind line_rasterizer_3d lr3_checker u_lr3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (command.valid),
	.in_ready  (command.ready),
	.in_cmd    (command.data.cmd),
	.out_valid (points.valid),
	.out_ready (points.ready),
	.out_data  (points.data)
);
`default_nettype wire
